// File: design/gbbs_pkg.sv
// Package for the grouped byte bit shifter.
// Shared widths, configuration register codes and the structs passed between blocks.
// No dependencies.
package gbbs_pkg;

  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int GS_W       = 5;
  localparam int SHIFT_W    = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_BITS = 1'b1;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] cnt;
    logic             eos;
  } desc_t;

  typedef struct packed {
    logic             right;
    logic [IDX_W-1:0] q;
    logic [2:0]       r;
  } shf_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

// File: design/gbbs_ifs.sv
// Channel interfaces of the grouped byte bit shifter: byte input, result output and
// configuration write. Depends on gbbs_pkg.
interface gbbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_section;

  modport source (output valid, output data_byte, output end_of_section, input ready);
  modport sink   (input valid, input data_byte, input end_of_section, output ready);
endinterface

interface gbbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       group_last;
  logic       section_last;

  modport source (output valid, output out_byte, output group_last, output section_last,
                  input ready);
  modport sink   (input valid, input out_byte, input group_last, input section_last,
                  output ready);
endinterface

interface gbbs_cfg_if;
  import gbbs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: design/grouped_byte_bit_shifter.sv
// Grouped byte bit shifter, top level.
// Connects the front end, the descriptor queue and the back end. Depends on gbbs_pkg,
// gbbs_ifs, gbbs_front, gbbs_fifo and gbbs_back.
//
// Bytes go in at up to one per cycle and shifted bytes come out one per cycle while
// the output is ready. A group is gathered in one of two banks while the previous
// group is read out of the other; apart from the remainder recompute below, input only
// stalls when both banks still hold unsent groups. A bank is freed only as its last
// byte is read, so short groups can leave the input idle while a bank waits to be freed.
// The first shifted byte of a group passes through the descriptor queue, the registered
// bank read and the output register, and the back end reads two bank entries per output
// byte from a two-read memory. After each configuration write the shift remainder is
// recomputed bit-serially, and input is held off while that runs.
module grouped_byte_bit_shifter #(
  parameter int GROUP_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbbs_in_if.sink    in_i,
  gbbs_out_if.source out_o,
  gbbs_cfg_if.sink   cfg_i
);
  import gbbs_pkg::*;

  logic  fifo_full;
  logic  fifo_empty;
  logic  push;
  logic  pop;
  desc_t push_desc;
  desc_t head;
  wr_t   wr;
  rel_t  rel;
  shf_t  shf;

  gbbs_front #(
    .GROUP_MAX(GROUP_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_desc_o (push_desc),
    .wr_o        (wr),
    .rel_i       (rel),
    .shf_o       (shf)
  );

  gbbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  gbbs_back #(
    .GROUP_MAX(GROUP_MAX)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .shf_i   (shf),
    .head_i  (head),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .rel_o   (rel),
    .out_o   (out_o)
  );

endmodule

// File: design/gbbs_front.sv
// Front end: configuration registers, shift modulo unit, byte collection into the
// ping-pong banks and group closing. Depends on gbbs_pkg and gbbs_ifs.
module gbbs_front #(
  parameter int GROUP_MAX = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  gbbs_in_if.sink         in_i,
  gbbs_cfg_if.sink        cfg_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output gbbs_pkg::desc_t push_desc_o,
  output gbbs_pkg::wr_t   wr_o,
  input  gbbs_pkg::rel_t  rel_i,
  output gbbs_pkg::shf_t  shf_o
);
  import gbbs_pkg::*;

  logic [GS_W-1:0]    gs_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [CNT_W-1:0]   gs_eff;
  logic [SHIFT_W:0]   sext;
  logic [SHIFT_W:0]   mag;
  logic               mod_busy_q;
  logic [3:0]         mod_cnt_q;
  logic [7:0]         mod_val_q;
  logic [GS_W:0]      mod_rem_q;
  logic [GS_W:0]      rem_t;
  logic [IDX_W-1:0]   q_q;
  logic [CNT_W-1:0]   fill_q;
  logic               wbank_q;
  logic [1:0]         busy_q;
  logic               accept;
  logic               close;
  logic               cfg_wr;

  always_comb begin
    if (gs_q == '0) begin
      gs_eff = CNT_W'(1);
    end else if ({{(CNT_W-GS_W){1'b0}}, gs_q} > CNT_W'(GROUP_MAX)) begin
      gs_eff = CNT_W'(GROUP_MAX);
    end else begin
      gs_eff = {{(CNT_W-GS_W){1'b0}}, gs_q};
    end
  end

  assign sext  = {shift_q[SHIFT_W-1], shift_q};
  assign mag   = shift_q[SHIFT_W-1] ? ((SHIFT_W+1)'(0) - sext) : sext;
  assign rem_t = {mod_rem_q[GS_W-1:0], mod_val_q[7]};

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q    <= GS_W'(1);
      shift_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_i.reg_index)
        CFG_GROUP_SIZE: gs_q    <= cfg_i.wdata[GS_W-1:0];
        CFG_SHIFT_BITS: shift_q <= cfg_i.wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // remainder of (magnitude / 8) by the group size, one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_busy_q <= 1'b0;
      mod_cnt_q  <= '0;
      mod_val_q  <= '0;
      mod_rem_q  <= '0;
      q_q        <= '0;
    end else if (cfg_wr) begin
      mod_busy_q <= 1'b1;
      mod_cnt_q  <= '0;
    end else if (mod_busy_q) begin
      if (mod_cnt_q == 4'd0) begin
        mod_val_q <= mag[10:3];
        mod_rem_q <= '0;
        mod_cnt_q <= 4'd1;
      end else begin
        mod_val_q <= {mod_val_q[6:0], 1'b0};
        if ({1'b0, rem_t} >= gs_eff) begin
          mod_rem_q <= (GS_W+1)'({1'b0, rem_t} - gs_eff);
        end else begin
          mod_rem_q <= rem_t;
        end
        if (mod_cnt_q == 4'd8) begin
          mod_busy_q <= 1'b0;
          if ({1'b0, rem_t} >= gs_eff) begin
            q_q <= IDX_W'({1'b0, rem_t} - gs_eff);
          end else begin
            q_q <= IDX_W'(rem_t);
          end
        end else begin
          mod_cnt_q <= mod_cnt_q + 4'd1;
        end
      end
    end
  end

  assign shf_o.right = !shift_q[SHIFT_W-1] && (shift_q != '0);
  assign shf_o.q     = q_q;
  assign shf_o.r     = mag[2:0];

  assign in_i.ready = !mod_busy_q && !busy_q[wbank_q] && !fifo_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign close      = ((fill_q + CNT_W'(1)) >= gs_eff) || in_i.end_of_section;

  assign wr_o.en   = accept;
  assign wr_o.bank = wbank_q;
  assign wr_o.idx  = IDX_W'(fill_q);
  assign wr_o.data = in_i.data_byte;

  assign push_o           = accept && close;
  assign push_desc_o.bank = wbank_q;
  assign push_desc_o.cnt  = fill_q + CNT_W'(1);
  assign push_desc_o.eos  = in_i.end_of_section;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      if (rel_i.en) begin
        busy_q[rel_i.bank] <= 1'b0;
      end
      if (accept) begin
        if (close) begin
          fill_q          <= '0;
          wbank_q         <= !wbank_q;
          busy_q[wbank_q] <= 1'b1;
        end else begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
    end
  end

endmodule

// File: design/gbbs_fifo.sv
// Two-entry request queue of closed group descriptors between front and back.
// Depends on gbbs_pkg.
module gbbs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gbbs_pkg::desc_t push_desc_i,
  input  logic            pop_i,
  output gbbs_pkg::desc_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import gbbs_pkg::*;

  desc_t      ent_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign head_o  = ent_q[rptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: design/gbbs_back.sv
// Back end: ping-pong group memory, byte index generation, registered reads and
// the output register. Depends on gbbs_pkg and gbbs_ifs.
module gbbs_back #(
  parameter int GROUP_MAX = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gbbs_pkg::wr_t   wr_i,
  input  gbbs_pkg::shf_t  shf_i,
  input  gbbs_pkg::desc_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output gbbs_pkg::rel_t  rel_o,
  gbbs_out_if.source      out_o
);
  import gbbs_pkg::*;

  localparam int AW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;

  logic [7:0]       mem_q [2][GROUP_MAX];
  logic             act_q;
  logic             bank_q;
  logic [CNT_W-1:0] cnt_q;
  logic             eos_q;
  logic [CNT_W-1:0] i_q;
  logic [CNT_W:0]   iw;
  logic [CNT_W:0]   qw;
  logic [CNT_W:0]   cw;
  logic [CNT_W:0]   a_idx;
  logic [CNT_W:0]   b_idx;
  logic             a_ok;
  logic             b_ok;
  logic             last;
  logic             issue;
  logic             take;
  logic             s1_v_q;
  logic [7:0]       a_q;
  logic [7:0]       b_q;
  logic             aok_q;
  logic             bok_q;
  logic             gl_q;
  logic             sl_q;
  logic             s1_mv;
  logic             out_ld;
  logic             ov_q;
  logic [7:0]       ob_q;
  logic             ogl_q;
  logic             osl_q;
  logic [7:0]       a_m;
  logic [7:0]       b_m;
  logic [15:0]      pr;
  logic [15:0]      pl;
  logic [7:0]       byte_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.bank][wr_i.idx[AW-1:0]] <= wr_i.data;
    end
  end

  assign iw = {1'b0, i_q};
  assign qw = {{(CNT_W+1-IDX_W){1'b0}}, shf_i.q};
  assign cw = {1'b0, cnt_q};

  always_comb begin
    if (shf_i.right) begin
      a_idx = iw - qw;
      b_idx = iw - qw - (CNT_W+1)'(1);
      a_ok  = iw >= qw;
      b_ok  = iw >= (qw + (CNT_W+1)'(1));
    end else begin
      a_idx = iw + qw;
      b_idx = iw + qw + (CNT_W+1)'(1);
      a_ok  = a_idx < cw;
      b_ok  = b_idx < cw;
    end
  end

  assign last   = (i_q + CNT_W'(1)) == cnt_q;
  assign out_ld = !ov_q || out_o.ready;
  assign s1_mv  = s1_v_q && out_ld;
  assign issue  = act_q && (!s1_v_q || s1_mv);
  assign take   = !empty_i && (!act_q || (issue && last));
  assign pop_o  = take;

  assign rel_o.en   = issue && last;
  assign rel_o.bank = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      bank_q <= 1'b0;
      cnt_q  <= '0;
      eos_q  <= 1'b0;
      i_q    <= '0;
    end else if (take) begin
      act_q  <= 1'b1;
      bank_q <= head_i.bank;
      cnt_q  <= head_i.cnt;
      eos_q  <= head_i.eos;
      i_q    <= '0;
    end else if (issue) begin
      if (last) begin
        act_q <= 1'b0;
      end
      i_q <= i_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_q   <= mem_q[bank_q][a_idx[AW-1:0]];
      b_q   <= mem_q[bank_q][b_idx[AW-1:0]];
      aok_q <= a_ok;
      bok_q <= b_ok;
      gl_q  <= last;
      sl_q  <= last && eos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (issue) begin
      s1_v_q <= 1'b1;
    end else if (s1_mv) begin
      s1_v_q <= 1'b0;
    end
  end

  assign a_m    = aok_q ? a_q : 8'h00;
  assign b_m    = bok_q ? b_q : 8'h00;
  assign pr     = {b_m, a_m} >> shf_i.r;
  assign pl     = {a_m, b_m} << shf_i.r;
  assign byte_d = shf_i.right ? pr[7:0] : pl[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_ld) begin
      ov_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_mv) begin
      ob_q  <= byte_d;
      ogl_q <= gl_q;
      osl_q <= sl_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.group_last   = ogl_q;
  assign out_o.section_last = osl_q;

endmodule
